FILE: rtl/core/stcp_pkg.sv
// stcp_pkg: shared widths, character codes, command and phase codes and
// the structs passed between the serial command parser top and its parse stage.
// No dependencies.
`timescale 1ns / 1ps

package stcp_pkg;

  // line buffer geometry (the line itself is never stored)
  localparam int LineLength = 16;
  localparam int PosW       = $clog2(LineLength);

  // payload widths
  localparam int ByteW   = 8;
  localparam int ValueW  = 16;
  localparam int CfgIdxW = 2;
  localparam int AccW    = ValueW + 4;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegDutyLimit = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFreqLow   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegFreqHigh  = 2'd2;

  // register reset values
  localparam logic [ValueW-1:0] DutyLimitRst = 16'd100;
  localparam logic [ValueW-1:0] FreqLowRst   = 16'd100;
  localparam logic [ValueW-1:0] FreqHighRst  = 16'd10000;

  // character codes
  localparam logic [ByteW-1:0] ChNewLine = 8'h0A;
  localparam logic [ByteW-1:0] ChTab     = 8'h09;
  localparam logic [ByteW-1:0] ChVtab    = 8'h0B;
  localparam logic [ByteW-1:0] ChFfeed   = 8'h0C;
  localparam logic [ByteW-1:0] ChCr      = 8'h0D;
  localparam logic [ByteW-1:0] ChSpace   = 8'h20;
  localparam logic [ByteW-1:0] ChPlus    = 8'h2B;
  localparam logic [ByteW-1:0] ChMinus   = 8'h2D;
  localparam logic [ByteW-1:0] ChZero    = 8'h30;
  localparam logic [ByteW-1:0] ChNine    = 8'h39;
  localparam logic [ByteW-1:0] ChColon   = 8'h3A;
  localparam logic [ByteW-1:0] ChDuty    = 8'h44;
  localparam logic [ByteW-1:0] ChFreq    = 8'h46;

  // command seen at the head of the line
  localparam logic [1:0] CmdNone = 2'd0;
  localparam logic [1:0] CmdDuty = 2'd1;
  localparam logic [1:0] CmdFreq = 2'd2;

  // number parse phase
  localparam logic [1:0] PhSpace  = 2'd0;
  localparam logic [1:0] PhSign   = 2'd1;
  localparam logic [1:0] PhDigits = 2'd2;
  localparam logic [1:0] PhDone   = 2'd3;

  // result kind
  localparam logic KindDuty = 1'b0;
  localparam logic KindFreq = 1'b1;

  localparam logic [ValueW-1:0] ValueMax = '1;

  typedef struct packed {
    logic [ValueW-1:0] duty_limit;
    logic [ValueW-1:0] freq_low;
    logic [ValueW-1:0] freq_high;
  } cfg_t;

  typedef struct packed {
    logic              valid;     // a command passed its range check
    logic              line_end;  // the word closed the line
    logic              kind;
    logic [ValueW-1:0] value;
  } res_t;

endpackage

FILE: rtl/core/stcp_intf.sv
// stcp channel interfaces: received byte, parsed command and register write.
// Depends on stcp_pkg.
`timescale 1ns / 1ps

interface stcp_byte_if;
  import stcp_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface stcp_cmd_if;
  import stcp_pkg::*;
  logic              valid;
  logic              ready;
  logic              command_kind;
  logic [ValueW-1:0] command_value;
  modport source (output valid, output command_kind, output command_value, input ready);
  modport sink (input valid, input command_kind, input command_value, output ready);
endinterface

interface stcp_cfg_if;
  import stcp_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [ValueW-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/stcp_parser.sv
// stcp_parser: per-line parse state and the one-word step that updates it
// and decides the command result at line end. Depends on stcp_pkg.
`timescale 1ns / 1ps

module stcp_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [stcp_pkg::ByteW-1:0] byte_i,
  input  stcp_pkg::cfg_t            cfg_i,
  output stcp_pkg::res_t            res_o
);
  import stcp_pkg::*;

  logic [PosW-1:0]   pos_q, pos_d;
  logic [1:0]        cmd_q, cmd_d;
  logic [1:0]        phase_q, phase_d;
  logic              neg_q, neg_d;
  logic [ValueW-1:0] mag_q, mag_d;

  logic            line_end;
  logic            is_blank;
  logic            is_digit;
  logic            nonneg;
  logic [AccW-1:0] acc;

  // character classes
  assign is_blank = (byte_i == ChSpace) || (byte_i == ChTab) || (byte_i == ChVtab) ||
                    (byte_i == ChFfeed) || (byte_i == ChCr);
  assign is_digit = (byte_i >= ChZero) && (byte_i <= ChNine);
  assign line_end = (byte_i == ChNewLine) || (pos_q == PosW'(LineLength - 1));
  assign nonneg   = !neg_q || (mag_q == '0);

  // magnitude times ten plus the new digit
  assign acc = {1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0} + AccW'(byte_i - ChZero);

  // result decision at line end
  always_comb begin
    res_o          = '0;
    res_o.line_end = line_end;
    res_o.value    = mag_q;
    if (line_end && (pos_q >= PosW'(2)) && nonneg) begin
      if (cmd_q == CmdDuty && mag_q <= cfg_i.duty_limit) begin
        res_o.valid = 1'b1;
        res_o.kind  = KindDuty;
      end else if (cmd_q == CmdFreq && mag_q >= cfg_i.freq_low &&
                   mag_q <= cfg_i.freq_high) begin
        res_o.valid = 1'b1;
        res_o.kind  = KindFreq;
      end
    end
  end

  // next parse state
  always_comb begin
    pos_d   = pos_q;
    cmd_d   = cmd_q;
    phase_d = phase_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    if (line_end) begin
      pos_d   = '0;
      cmd_d   = CmdNone;
      phase_d = PhSpace;
      neg_d   = 1'b0;
      mag_d   = '0;
    end else begin
      pos_d = pos_q + PosW'(1);
      if (pos_q == '0) begin
        if (byte_i == ChDuty) cmd_d = CmdDuty;
        else if (byte_i == ChFreq) cmd_d = CmdFreq;
        else cmd_d = CmdNone;
      end else if (pos_q == PosW'(1)) begin
        if (byte_i != ChColon) cmd_d = CmdNone;
      end else if (phase_q != PhDone) begin
        if (phase_q == PhSpace && is_blank) begin
          phase_d = phase_q;
        end else if (phase_q == PhSpace && (byte_i == ChPlus || byte_i == ChMinus)) begin
          neg_d   = (byte_i == ChMinus);
          phase_d = PhSign;
        end else if (!is_digit) begin
          phase_d = PhDone;
        end else begin
          phase_d = PhDigits;
          // saturate where the value leaves 16 bits
          mag_d   = (acc > AccW'(ValueMax)) ? ValueMax : acc[ValueW-1:0];
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      cmd_q   <= CmdNone;
      phase_q <= PhSpace;
      neg_q   <= 1'b0;
      mag_q   <= '0;
    end else if (step_i) begin
      pos_q   <= pos_d;
      cmd_q   <= cmd_d;
      phase_q <= phase_d;
      neg_q   <= neg_d;
      mag_q   <= mag_d;
    end
  end

endmodule

FILE: rtl/core/serial_text_command_parser_top.sv
// serial_text_command_parser_top: parses D:n / F:n lines from received bytes.
// Depends on stcp_pkg, stcp_intf and stcp_parser.
//
//   channel  dir  handshake    payload
//   rx_i     in   valid/ready  rx_byte[7:0]
//   cmd_o    out  valid/ready  command_kind, command_value[15:0]
//   cfg_i    in   valid/ready  index[1:0], data[15:0] (ready always high)
//
// One word per cycle while cmd_o is not stalled: a word is parsed once it
// sits in the input register, and its result is registered onto cmd_o.
// A result is valid once its closing word has passed the input register
// and the parse stage into the result register, and is held until taken.
// Reset returns the registers to their default limits and empties the line.
// A stalled result holds the parse stage; the input register still takes
// one word, then ready drops until the result is taken.
`timescale 1ns / 1ps

module serial_text_command_parser_top (
  input logic         clk_i,
  input logic         rst_ni,
  stcp_byte_if.sink   rx_i,
  stcp_cmd_if.source  cmd_o,
  stcp_cfg_if.sink    cfg_i
);
  import stcp_pkg::*;

  cfg_t              cfg_q;
  logic              in_valid_q;
  logic [ByteW-1:0]  byte_q;
  logic              out_valid_q;
  logic              kind_q;
  logic [ValueW-1:0] value_q;
  logic              advance;
  res_t              res;

  // parse stage moves when the result slot is free or draining
  assign advance     = in_valid_q && (!out_valid_q || cmd_o.ready);
  assign rx_i.ready  = !in_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.duty_limit <= DutyLimitRst;
      cfg_q.freq_low   <= FreqLowRst;
      cfg_q.freq_high  <= FreqHighRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        RegDutyLimit: cfg_q.duty_limit <= cfg_i.data;
        RegFreqLow:   cfg_q.freq_low   <= cfg_i.data;
        RegFreqHigh:  cfg_q.freq_high  <= cfg_i.data;
        default:      cfg_q            <= cfg_q;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.valid && rx_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      byte_q <= rx_i.rx_byte;
    end
  end

  // parse stage
  stcp_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (byte_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid_q <= 1'b1;
    end else if (cmd_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.valid) begin
      kind_q  <= res.kind;
      value_q <= res.value;
    end
  end

  assign cmd_o.valid         = out_valid_q;
  assign cmd_o.command_kind  = kind_q;
  assign cmd_o.command_value = value_q;

`ifndef SYNTHESIS
  // results are produced only by a word that closes the line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res.valid) |-> res.line_end)
    else $error("result from a word that does not end the line");

  // a duty result respects the duty limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res.valid && res.kind == KindDuty) |-> (res.value <= cfg_q.duty_limit))
    else $error("duty result above limit");

  // a frequency result lies inside the window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res.valid && res.kind == KindFreq) |->
      (res.value >= cfg_q.freq_low && res.value <= cfg_q.freq_high))
    else $error("frequency result outside window");

  // a waiting result is never overwritten by the parse stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !cmd_o.ready) |=> (out_valid_q && $stable(value_q) && $stable(kind_q)))
    else $error("pending result lost");
`endif

endmodule

FILE: tb/sv/serial_text_command_parser_top_test.sv
`timescale 1ns / 1ps
// serial_text_command_parser_top_test: feeds received bytes and limit writes to the parser
// and checks every command word against a shadow line parser or, for typed rows, their own expected command.
// Depends on stcp_pkg, stcp_intf and serial_text_command_parser_top.

module serial_text_command_parser_top_test;
  import stcp_pkg::*;

  localparam int HalfPeriodNs  = 10;
  localparam int ResetCycles   = 10;
  localparam int DrainCycles   = 8;
  localparam int HoldCycles    = 300;
  localparam int PhaseCount    = 7;
  localparam int BytesPerPhase = 265;
  localparam int MaxReports    = 40;
  localparam int RowCount      = 22;

  typedef struct packed {
    logic              kind;
    logic [ValueW-1:0] value;
  } command_t;

  // one directed line; typed rows carry their own expected command
  typedef struct {
    string             text;
    bit                typed;
    bit                want;
    logic              kind;
    logic [ValueW-1:0] value;
  } line_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  stcp_byte_if rx_if ();
  stcp_cmd_if  cmd_if ();
  stcp_cfg_if  cfg_if ();

  serial_text_command_parser_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .cmd_o  (cmd_if),
    .cfg_i  (cfg_if)
  );

  // shadow copy of the limits and of the line parse
  cfg_t              shadow_cfg;
  int                line_pos;
  logic [1:0]        line_cmd;
  logic [1:0]        num_phase;
  logic              num_neg;
  logic [ValueW-1:0] num_mag;
  command_t          pending_commands[$];

  logic [ByteW-1:0]  blank_chars [5];
  line_row_t         directed_rows [RowCount];
  cfg_t              phase_cfg [PhaseCount];

  int mismatch_count = 0;
  int bytes_sent     = 0;
  int commands_seen  = 0;
  int holds_done     = 0;
  bit source_gaps    = 1'b1;
  bit sink_stalls    = 1'b1;
  bit long_hold_req  = 1'b0;

  always begin
    #HalfPeriodNs clk_i = 1'b1;
    #HalfPeriodNs clk_i = 1'b0;
  end

  task automatic flag_mismatch(input string what);
    if (mismatch_count < MaxReports) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    mismatch_count++;
  endtask

  // advance the shadow parser by one byte; keep selects whether a command is queued
  task automatic shadow_parse_byte(input logic [ByteW-1:0] b, input bit keep);
    int       acc;
    bit       blank;
    bit       digit;
    command_t hit;
    blank = (b == ChSpace) || (b == ChTab) || (b == ChVtab) || (b == ChFfeed) || (b == ChCr);
    digit = (b >= ChZero) && (b <= ChNine);
    if (b == ChNewLine || line_pos >= LineLength - 1) begin
      // line closes: range check against the command letter
      if (keep && line_pos >= 2 && (!num_neg || num_mag == '0)) begin
        hit.value = num_mag;
        if (line_cmd == CmdDuty && num_mag <= shadow_cfg.duty_limit) begin
          hit.kind = KindDuty;
          pending_commands.push_back(hit);
        end else if (line_cmd == CmdFreq && num_mag >= shadow_cfg.freq_low &&
                     num_mag <= shadow_cfg.freq_high) begin
          hit.kind = KindFreq;
          pending_commands.push_back(hit);
        end
      end
      line_pos  = 0;
      line_cmd  = CmdNone;
      num_phase = PhSpace;
      num_neg   = 1'b0;
      num_mag   = '0;
    end else begin
      if (line_pos == 0) begin
        if (b == ChDuty) line_cmd = CmdDuty;
        else if (b == ChFreq) line_cmd = CmdFreq;
        else line_cmd = CmdNone;
      end else if (line_pos == 1) begin
        if (b != ChColon) line_cmd = CmdNone;
      end else if (num_phase != PhDone && !(num_phase == PhSpace && blank)) begin
        // atoi style: one sign after the blanks, then digits up to any other byte
        if (num_phase == PhSpace && (b == ChPlus || b == ChMinus)) begin
          num_neg   = (b == ChMinus);
          num_phase = PhSign;
        end else if (!digit) begin
          num_phase = PhDone;
        end else begin
          num_phase = PhDigits;
          acc       = int'(num_mag) * 10 + int'(b) - int'(ChZero);
          num_mag   = (acc > int'(ValueMax)) ? ValueMax : acc[ValueW-1:0];
        end
      end
      line_pos++;
    end
  endtask

  // offer one byte word, starting and ending at a falling edge
  task automatic put_byte(input logic [ByteW-1:0] b, input bit keep);
    if (source_gaps && $urandom_range(0, 4) == 0) begin
      rx_if.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    rx_if.valid   = 1'b1;
    rx_if.rx_byte = b;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    shadow_parse_byte(b, keep);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ValueW-1:0] data);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      RegDutyLimit: shadow_cfg.duty_limit = data;
      RegFreqLow:   shadow_cfg.freq_low   = data;
      RegFreqHigh:  shadow_cfg.freq_high  = data;
      default:      ;
    endcase
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // mostly well formed lines with random content, some broken ones and raw noise
  task automatic send_random_line();
    logic [ByteW-1:0] line_q[$];
    int               pick;
    int               val;
    int               lo;
    int               hi;
    int               i;
    bit               duty;
    string            digits;
    pick = $urandom_range(0, 99);
    duty = $urandom_range(0, 1);
    if (pick < 85) begin
      // command letter and colon, spoiled on some lines
      if (pick >= 72 && pick < 78) line_q.push_back(ByteW'($urandom_range(0, 255)));
      else line_q.push_back(duty ? ChDuty : ChFreq);
      if (pick >= 78) line_q.push_back(ByteW'($urandom_range(0, 255)));
      else line_q.push_back(ChColon);
      repeat ($urandom_range(0, 2)) line_q.push_back(blank_chars[$urandom_range(0, 4)]);
      case ($urandom_range(0, 9))
        0:       line_q.push_back(ChPlus);
        1:       line_q.push_back(ChMinus);
        default: ;
      endcase
      // value mostly near the window of the chosen command
      if (duty) begin
        lo = 0;
        hi = int'(shadow_cfg.duty_limit) + 3;
      end else begin
        lo = int'(shadow_cfg.freq_low) - 20;
        hi = int'(shadow_cfg.freq_high) + 20;
      end
      if (lo < 0) lo = 0;
      case ($urandom_range(0, 9))
        0:       val = $urandom_range(0, 99999);
        1:       val = duty ? int'(shadow_cfg.duty_limit) : int'(shadow_cfg.freq_low);
        2:       val = duty ? int'(shadow_cfg.duty_limit) + 1 : int'(shadow_cfg.freq_high);
        3:       val = -1;
        default: val = $urandom_range(hi, lo);
      endcase
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 3)) line_q.push_back(ChZero);
      end
      if (val >= 0) begin
        digits = $sformatf("%0d", val);
        for (i = 0; i < digits.len(); i++) line_q.push_back(digits[i]);
      end
      if ($urandom_range(0, 5) == 0) line_q.push_back(ByteW'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) == 0) begin
        // fill to the length limit; the last byte closes the line
        while (line_q.size() < LineLength) begin
          line_q.push_back(ByteW'($urandom_range(ChZero, ChNine)));
        end
      end else begin
        line_q.push_back(ChNewLine);
      end
    end else begin
      repeat ($urandom_range(1, 20)) line_q.push_back(ByteW'($urandom_range(0, 255)));
    end
    foreach (line_q[k]) put_byte(line_q[k], 1'b1);
  endtask

  // result sink: random ready bursts, plus one long hold on request
  initial begin : result_sink
    cmd_if.ready = 1'b0;
    @(negedge clk_i);
    forever begin
      if (long_hold_req) begin
        cmd_if.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        long_hold_req = 1'b0;
        holds_done++;
      end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
        cmd_if.ready = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end else begin
        cmd_if.ready = 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end
    end
  end

  // compare each accepted command word with the oldest expectation
  always @(posedge clk_i) begin : check_commands
    command_t want;
    if (rst_ni && cmd_if.valid && cmd_if.ready) begin
      commands_seen++;
      if (pending_commands.size() == 0) begin
        flag_mismatch($sformatf("unexpected command kind %0d value %0d",
                                cmd_if.command_kind, cmd_if.command_value));
      end else begin
        want = pending_commands.pop_front();
        if (cmd_if.command_kind !== want.kind) begin
          flag_mismatch($sformatf("command_kind %0d, expected %0d",
                                  cmd_if.command_kind, want.kind));
        end
        if (cmd_if.command_value !== want.value) begin
          flag_mismatch($sformatf("command_value %0d, expected %0d",
                                  cmd_if.command_value, want.value));
        end
      end
    end
  end

  initial begin : stimulus
    line_row_t        row;
    command_t         exp_cmd;
    logic [ByteW-1:0] c;
    int               i;
    int               phase;
    int               phase_start;

    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = RegDutyLimit;
    cfg_if.data   = '0;

    shadow_cfg.duty_limit = DutyLimitRst;
    shadow_cfg.freq_low   = FreqLowRst;
    shadow_cfg.freq_high  = FreqHighRst;
    line_pos  = 0;
    line_cmd  = CmdNone;
    num_phase = PhSpace;
    num_neg   = 1'b0;
    num_mag   = '0;

    blank_chars = '{ChSpace, ChTab, ChVtab, ChFfeed, ChCr};

    // in the text: ~ is 0x00, ^ is 0xff, | is VT, $ is FF, < is CR
    directed_rows = '{
      '{"D:7\n",             1'b1, 1'b1, KindDuty, 16'd7},
      '{"D:100\n",           1'b1, 1'b1, KindDuty, 16'd100},
      '{"D:101\n",           1'b1, 1'b0, KindDuty, 16'd0},
      '{"F:100\n",           1'b1, 1'b1, KindFreq, 16'd100},
      '{"F:10000\n",         1'b1, 1'b1, KindFreq, 16'd10000},
      '{"F:99\n",            1'b1, 1'b0, KindFreq, 16'd0},
      '{"D\n",               1'b1, 1'b0, KindDuty, 16'd0},
      '{"\n",                1'b1, 1'b0, KindDuty, 16'd0},
      '{"D:\n",              1'b1, 1'b1, KindDuty, 16'd0},
      '{"D: \t-0\n",         1'b1, 1'b1, KindDuty, 16'd0},
      '{"F:|$<\t+250\n",     1'b1, 1'b1, KindFreq, 16'd250},
      '{"D:1~2\n",           1'b1, 1'b1, KindDuty, 16'd1},
      '{"D:-5\n",            1'b1, 1'b0, KindDuty, 16'd0},
      '{"F:99999\n",         1'b1, 1'b0, KindFreq, 16'd0},
      '{"X:5\n",             1'b1, 1'b0, KindDuty, 16'd0},
      '{"D;5\n",             1'b1, 1'b0, KindDuty, 16'd0},
      '{"^\n",               1'b1, 1'b0, KindDuty, 16'd0},
      '{"D:+0000000000509",  1'b1, 1'b1, KindDuty, 16'd50},
      '{"D:42 7\n",          1'b0, 1'b0, KindDuty, 16'd0},
      '{"F:00512xy\n",       1'b0, 1'b0, KindFreq, 16'd0},
      '{"D:++3\n",           1'b0, 1'b0, KindDuty, 16'd0},
      '{"F:-0\n",            1'b0, 1'b0, KindFreq, 16'd0}
    };

    // limit settings per phase, the first one being the reset values
    phase_cfg[0] = shadow_cfg;
    phase_cfg[1] = '{16'd0, 16'd0, 16'd0};
    phase_cfg[2] = '{16'd65534, 16'd65534, 16'd65534};
    phase_cfg[3] = '{16'd65534, 16'd0, 16'd65534};
    phase_cfg[4] = '{ValueW'($urandom_range(0, 65534)), ValueW'($urandom_range(0, 65534)),
                     ValueW'($urandom_range(0, 65534))};
    phase_cfg[5] = '{ValueMax, ValueMax, ValueMax};
    phase_cfg[6] = '{ValueW'($urandom_range(0, 2000)), ValueW'($urandom_range(0, 2000)),
                     ValueW'($urandom_range(2000, 65534))};

    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    for (phase = 0; phase < PhaseCount; phase++) begin
      if (phase > 0) begin
        // let the parser drain before touching its limits
        rx_if.valid = 1'b0;
        while (pending_commands.size() != 0) @(negedge clk_i);
        repeat (DrainCycles) @(negedge clk_i);
        write_reg(RegDutyLimit, phase_cfg[phase].duty_limit);
        write_reg(RegFreqLow, phase_cfg[phase].freq_low);
        write_reg(RegFreqHigh, phase_cfg[phase].freq_high);
      end else begin
        foreach (directed_rows[r]) begin
          row = directed_rows[r];
          for (i = 0; i < row.text.len(); i++) begin
            case (row.text[i])
              "~":     c = '0;
              "^":     c = '1;
              "|":     c = ChVtab;
              "$":     c = ChFfeed;
              "<":     c = ChCr;
              default: c = row.text[i];
            endcase
            put_byte(c, !row.typed);
          end
          // the closing byte was just taken, its command has not yet reached cmd_o
          if (row.typed && row.want) begin
            exp_cmd.kind  = row.kind;
            exp_cmd.value = row.value;
            pending_commands.push_back(exp_cmd);
          end
        end
      end
      if (phase == 2) long_hold_req = 1'b1;
      if (phase == PhaseCount - 1) begin
        source_gaps = 1'b0;
        sink_stalls = 1'b0;
      end
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < BytesPerPhase) send_random_line();
    end

    rx_if.valid = 1'b0;
    while (pending_commands.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d bytes sent under %0d limit settings, %0d command words compared",
             bytes_sent, PhaseCount, commands_seen);
    $display("result side held off %0d time(s) for %0d cycles with input still offered",
             holds_done, HoldCycles);
    if (mismatch_count == 0) begin
      $display("serial_text_command_parser_top verification clean");
    end else begin
      $display("serial_text_command_parser_top verification failed");
    end
    $finish;
  end

  // run limit, several times the slowest legal run
  initial begin : watchdog
    #4_000_000;
    $display("timeout waiting for the parser");
    $display("serial_text_command_parser_top verification failed");
    $finish;
  end

endmodule
